// ===== hw/rtl/rtcc_pkg.sv =====
`timescale 1ns / 1ps
package rtcc_pkg;

  localparam int unsigned TIME_W = 22;
  localparam int unsigned DATE_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [TIME_W-1:0] TIME_RESET = '0;
  localparam logic [DATE_W-1:0] DATE_RESET = 32'h2017_0408;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_LOAD_TIME = 2'd1,
    MODE_LOAD_DATE = 2'd2,
    MODE_UNUSED    = 2'd3
  } rtcc_mode_t;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_ALARM_TIME = 1'b0,
    REG_ALARM_EN   = 1'b1
  } rtcc_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] alarm_time;
    logic              alarm_enable;
  } rtcc_cfg_t;

  // days in month 1..12, non-leap
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2:                       days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    days = 5'd30;
      default:                    days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// ===== hw/rtl/rtcc_cfg_regs.sv =====
`timescale 1ns / 1ps
module rtcc_cfg_regs
  import rtcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output rtcc_cfg_t             cfg
);

  rtcc_cfg_t cfg_r;
  rtcc_reg_t sel_reg;
  logic      wr_en;

  assign sel_reg = rtcc_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (sel_reg)
        REG_ALARM_TIME: cfg_r.alarm_time   <= pwdata[TIME_W-1:0];
        REG_ALARM_EN:   cfg_r.alarm_enable <= pwdata[0];
        default:        cfg_r              <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel_reg)
      REG_ALARM_TIME: prdata = {{(CFG_DATA_W-TIME_W){1'b0}}, cfg_r.alarm_time};
      REG_ALARM_EN:   prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.alarm_enable};
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/rtcc_time_step.sv =====
`timescale 1ns / 1ps
module rtcc_time_step
  import rtcc_pkg::*;
(
  input  logic [TIME_W-1:0] time_cur,
  output logic [TIME_W-1:0] time_nxt
);

  logic [3:0] s0, s1, m0, m1, h0;
  logic [1:0] ht;
  logic [3:0] s0_n, s1_n, m0_n, m1_n, h0_n;
  logic [1:0] ht_n;
  logic       c0, c1, c2, c3, c4;

  assign s0 = time_cur[3:0];
  assign s1 = time_cur[7:4];
  assign m0 = time_cur[11:8];
  assign m1 = time_cur[15:12];
  assign h0 = time_cur[19:16];
  assign ht = time_cur[21:20];

  // out-of-range digits clear and carry
  assign c0 = (s0 >= 4'd9);
  assign c1 = c0 && (s1 >= 4'd5);
  assign c2 = c1 && (m0 >= 4'd9);
  assign c3 = c2 && (m1 >= 4'd5);
  assign c4 = c3 && (h0 >= 4'd9);

  assign s0_n = c0 ? 4'd0 : s0 + 4'd1;
  assign s1_n = !c0 ? s1 : (c1 ? 4'd0 : s1 + 4'd1);
  assign m0_n = !c1 ? m0 : (c2 ? 4'd0 : m0 + 4'd1);
  assign m1_n = !c2 ? m1 : (c3 ? 4'd0 : m1 + 4'd1);
  assign h0_n = !c3 ? h0 : (c4 ? 4'd0 : h0 + 4'd1);
  assign ht_n = c4 ? ht + 2'd1 : ht;

  // hour range is checked only when the hour moved
  always_comb begin
    if (c3 && ({ht_n, h0_n} >= 6'h24)) begin
      time_nxt = '0;
    end else begin
      time_nxt = {ht_n, h0_n, m1_n, m0_n, s1_n, s0_n};
    end
  end

endmodule

// ===== hw/rtl/rtcc_date_step.sv =====
`timescale 1ns / 1ps
module rtcc_date_step
  import rtcc_pkg::*;
(
  input  logic [DATE_W-1:0] date_cur,
  output logic [DATE_W-1:0] date_nxt
);

  function automatic logic [7:0] to_bcd2(input logic [5:0] v);
    logic [7:0] r;
    if (v >= 6'd30)      r = {4'd3, 4'(v - 6'd30)};
    else if (v >= 6'd20) r = {4'd2, 4'(v - 6'd20)};
    else if (v >= 6'd10) r = {4'd1, 4'(v - 6'd10)};
    else                 r = {4'd0, v[3:0]};
    return r;
  endfunction

  logic [5:0]  day_p1;
  logic [4:0]  month;
  logic [7:0]  leap_sel;
  logic [7:0]  leap_tst;
  logic        leap;
  logic [5:0]  limit;
  logic        roll;
  logic [15:0] year_inc;
  logic        carry;
  logic [3:0]  dig;

  assign day_p1 = 6'(date_cur[3:0]) + 6'({date_cur[5:4], 3'b000})
                + 6'({date_cur[5:4], 1'b0}) + 6'd1;
  assign month  = 5'(date_cur[11:8]) + (date_cur[12] ? 5'd10 : 5'd0);

  // gregorian leap test on bcd digits
  assign leap_sel = (date_cur[23:16] != 8'h00) ? date_cur[23:16] : date_cur[31:24];
  assign leap_tst = leap_sel & 8'h13;
  assign leap     = (leap_tst == 8'h00) || (leap_tst == 8'h12);

  assign limit = 6'(month_days(month[3:0])) + ((month == 5'd2 && leap) ? 6'd1 : 6'd0);
  assign roll  = (month == 5'd0) || (month > 5'd12) || (day_p1 > limit);

  always_comb begin
    carry    = 1'b1;
    year_inc = date_cur[31:16];
    for (int k = 0; k < 4; k++) begin
      dig = date_cur[16 + 4*k +: 4];
      if (carry) begin
        if (dig >= 4'd9) begin
          year_inc[4*k +: 4] = 4'd0;
        end else begin
          year_inc[4*k +: 4] = dig + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (!roll) begin
      date_nxt = {date_cur[31:8], to_bcd2(day_p1)};
    end else if (month == 5'd0) begin
      date_nxt = {date_cur[31:16], 16'h0101};
    end else if (month < 5'd12) begin
      date_nxt = {date_cur[31:16], to_bcd2(6'(month) + 6'd1), 8'h01};
    end else begin
      date_nxt = {year_inc, 16'h0101};
    end
  end

endmodule

// ===== hw/rtl/bcd_time_and_calendar_counter_core.sv =====
`timescale 1ns / 1ps
// path: the input beat is captured in the input register (stage 1), and its result is
// written from there to the result register, which holds it while out_tready is low
// throughput: one item per cycle while out_tready stays high; the time and date update is a
// single pass of carry logic between the input register and the result register
// reset (synchronous, rst_n low): time 00:00:00, date 2017-04-08, alarm registers cleared,
// both pipeline stages emptied
module bcd_time_and_calendar_counter_core
  import rtcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] load_value
  input  logic [1:0]            in_tuser,   // [1:0] mode
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [21:0] time_bcd, [53:22] date_bcd,
                                            // [54] alarm_hit, [55] new_day
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  rtcc_cfg_t cfg;

  // input register stage
  logic              s1_valid_r;
  rtcc_mode_t        s1_mode_r;
  logic [31:0]       s1_load_r;

  // clock and calendar state
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [DATE_W-1:0] date_r, date_nxt;

  // result register stage
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [TIME_W-1:0] tick_time;
  logic [DATE_W-1:0] tick_date;
  logic              alarm_hit, new_day;
  logic              advance;
  logic              in_beat;

  assign cfg_pready = 1'b1;

  rtcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  rtcc_time_step u_time (
    .time_cur (time_r),
    .time_nxt (tick_time)
  );

  rtcc_date_step u_date (
    .date_cur (date_r),
    .date_nxt (tick_date)
  );

  // stage 1 moves on whenever the result register is free or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  // one pass: next time, next date and flags for the item in stage 1
  always_comb begin
    time_nxt  = time_r;
    date_nxt  = date_r;
    alarm_hit = 1'b0;
    new_day   = 1'b0;
    unique case (s1_mode_r)
      MODE_TICK: begin
        time_nxt  = tick_time;
        alarm_hit = cfg.alarm_enable && (tick_time == cfg.alarm_time);
        if (tick_time == '0) begin
          // midnight wrap advances the calendar
          date_nxt = tick_date;
          new_day  = 1'b1;
        end
      end
      MODE_LOAD_TIME: time_nxt = s1_load_r[TIME_W-1:0];
      MODE_LOAD_DATE: date_nxt = s1_load_r;
      MODE_UNUSED: begin
        time_nxt = time_r;
      end
      default: begin
        time_nxt = time_r;
      end
    endcase
    out_data_nxt = {new_day, alarm_hit, date_nxt, time_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      time_r      <= TIME_RESET;
      date_r      <= DATE_RESET;
    end else begin
      if (in_beat) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        time_r      <= time_nxt;
        date_r      <= date_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_mode_r <= rtcc_mode_t'(in_tuser);
      s1_load_r <= in_tdata;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/rtcc_checker.sv =====
`timescale 1ns / 1ps
module rtcc_checker
  import rtcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a new day only comes with the time at midnight
  a_new_day_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[55] |-> out_tdata[21:0] == 22'h0)
    else $error("new day flagged away from midnight");

  // an advanced date never shows day zero
  a_new_day_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[55] |-> out_tdata[29:22] != 8'h00)
    else $error("advanced date has day zero");

endmodule

bind bcd_time_and_calendar_counter_core rtcc_checker u_rtcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb_bcd_time_and_calendar_counter_core.sv =====
`timescale 1ns / 1ps
module tb_bcd_time_and_calendar_counter_core;
  import rtcc_pkg::*;

  // one result beat as the block reports it
  typedef struct packed {
    logic [TIME_W-1:0] tod;
    logic [DATE_W-1:0] date;
    logic              alarm;
    logic              rollover;
  } rtc_result_t;

  // directed stimulus row; want is only used when typed is set
  typedef struct packed {
    rtcc_mode_t  mode;
    logic [31:0] value;
    logic        typed;
    rtc_result_t want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 24;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // [31:0] load_value
  logic [1:0]            in_tuser;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [21:0] time_bcd, [53:22] date_bcd,
                                     // [54] alarm_hit, [55] new_day
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // shadow copy of the clock/calendar state and the alarm registers
  logic [TIME_W-1:0] cur_tod;
  logic [DATE_W-1:0] cur_date;
  logic [TIME_W-1:0] alarm_at;
  logic              alarm_on;

  rtc_result_t pending_results [$];
  rtc_result_t got_res;
  rtc_result_t want_res;
  stim_row_t   dir_rows [NUM_DIRECTED];

  int  errors;
  int  results_seen;
  int  items_sent;
  bit  calm;          // no idling on either side while set
  bit  stall_req;     // asks the result side for one long hold-off
  bit  stall_served;

  bcd_time_and_calendar_counter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // clock/calendar predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // one-second step; non-bcd digits wrap to zero and carry, hour tens is 2 bits
  function automatic logic [TIME_W-1:0] next_second(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] n;
    n = t;
    if (n[3:0] < 4'd9) begin
      n[3:0] = n[3:0] + 4'd1;
      return n;
    end
    n[3:0] = 4'd0;
    if (n[7:4] < 4'd5) begin
      n[7:4] = n[7:4] + 4'd1;
      return n;
    end
    n[7:4] = 4'd0;
    if (n[11:8] < 4'd9) begin
      n[11:8] = n[11:8] + 4'd1;
      return n;
    end
    n[11:8] = 4'd0;
    if (n[15:12] < 4'd5) begin
      n[15:12] = n[15:12] + 4'd1;
      return n;
    end
    n[15:12] = 4'd0;
    if (n[19:16] < 4'd9) begin
      n[19:16] = n[19:16] + 4'd1;
    end else begin
      n[19:16] = 4'd0;
      n[21:20] = n[21:20] + 2'd1;
    end
    // past 23 hours the whole time clears
    if (n[21:16] >= 6'h24) n = '0;
    return n;
  endfunction

  // leap test on the low year byte, or the century byte when that is 00
  function automatic bit leap_year(input logic [DATE_W-1:0] d);
    logic [7:0] yy;
    yy = (d[23:16] != 8'h00) ? d[23:16] : d[31:24];
    yy = yy & 8'h13;
    return (yy == 8'h00) || (yy == 8'h12);
  endfunction

  function automatic logic [DATE_W-1:0] next_day(input logic [DATE_W-1:0] d);
    int day;
    int mon;
    int lim;
    int k;
    logic [DATE_W-1:0] n;
    day = int'(d[3:0]) + 10 * int'(d[5:4]) + 1;
    mon = int'(d[11:8]) + 10 * int'(d[12]);
    if (mon >= 1 && mon <= 12) begin
      lim = MONTH_DAYS[mon-1];
      if (mon == 2 && leap_year(d)) lim = lim + 1;
      if (day <= lim) begin
        n = d;
        n[7:0] = to_bcd(day);
        return n;
      end
    end
    // day rolls over: day 01, upper month bits cleared
    n = {d[31:16], 16'h0001};
    if (mon == 0) begin
      n[15:8] = 8'h01;
    end else if (mon < 12) begin
      n[15:8] = to_bcd(mon + 1);
    end else begin
      // december or a bogus month: january of next year, 9999 wraps
      n[15:8] = 8'h01;
      for (k = 16; k < 32; k += 4) begin
        if (n[k+:4] < 4'd9) begin
          n[k+:4] = n[k+:4] + 4'd1;
          break;
        end
        n[k+:4] = 4'd0;
      end
    end
    return n;
  endfunction

  // apply one accepted beat to the shadow state, return the result it causes
  function automatic rtc_result_t clock_step(input rtcc_mode_t mode, input logic [31:0] value);
    rtc_result_t r;
    r.alarm = 1'b0;
    r.rollover = 1'b0;
    case (mode)
      MODE_TICK: begin
        cur_tod = next_second(cur_tod);
        if (alarm_on && cur_tod == alarm_at) r.alarm = 1'b1;
        if (cur_tod == '0) begin
          cur_date = next_day(cur_date);
          r.rollover = 1'b1;
        end
      end
      MODE_LOAD_TIME: cur_tod = value[TIME_W-1:0];
      MODE_LOAD_DATE: cur_date = value;
      default: ;
    endcase
    r.tod = cur_tod;
    r.date = cur_date;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s at result %0d: got %h, expected %h",
             field, results_seen, got, want);
    errors++;
  endtask

  // results are sampled at the rising edge, before the block's own updates land
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.tod = out_tdata[21:0];
      got_res.date = out_tdata[53:22];
      got_res.alarm = out_tdata[54];
      got_res.rollover = out_tdata[55];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(got_res.tod), 32'h0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.tod !== want_res.tod)
          report_mismatch("time_bcd", 32'(got_res.tod), 32'(want_res.tod));
        if (got_res.date !== want_res.date)
          report_mismatch("date_bcd", got_res.date, want_res.date);
        if (got_res.alarm !== want_res.alarm)
          report_mismatch("alarm_hit", 32'(got_res.alarm), 32'(want_res.alarm));
        if (got_res.rollover !== want_res.rollover)
          report_mismatch("new_day", 32'(got_res.rollover), 32'(want_res.rollover));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random backpressure, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    out_tready = 1'b0;
    stall_served = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_req && !stall_served) begin
        // hold off long enough for the block to fill and stall its input
        stall_served = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at a falling edge with the beat still held
  task automatic send_item(input rtcc_mode_t mode, input logic [31:0] value,
                           input logic typed, input rtc_result_t typed_want);
    rtc_result_t predicted;
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    predicted = clock_step(mode, value);
    pending_results.push_back(typed ? typed_want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input rtcc_reg_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_ALARM_TIME) alarm_at = value[TIME_W-1:0];
    else alarm_on = value[0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    // idle before returning so a following write starts on a fresh edge
    @(negedge clk);
  endtask

  // let every outstanding result drain before touching the registers
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [TIME_W-1:0] random_valid_time;
    logic [7:0] hh;
    logic [7:0] mm;
    logic [7:0] ss;
    hh = to_bcd($urandom_range(0, 23));
    mm = to_bcd($urandom_range(0, 59));
    ss = to_bcd($urandom_range(0, 59));
    return {hh[5:0], mm, ss};
  endfunction

  // mostly just before midnight or at the start of the alarm minute
  function automatic logic [31:0] random_load_time;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return {10'h0, 6'h23, 8'h59, 4'h5, 4'($urandom_range(0, 9))};
    if (pick < 70) return {10'h0, alarm_at[21:8], 8'h00};
    if (pick < 90) return {10'($urandom()), random_valid_time()};
    return $urandom();
  endfunction

  // mostly well-formed dates near a month end so that rollovers show up
  function automatic logic [31:0] random_load_date;
    int pick;
    int mon;
    int day;
    logic [15:0] year;
    pick = $urandom_range(0, 99);
    if (pick < 15) return $urandom();
    year = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    mon = $urandom_range(1, 12);
    if (pick < 30) begin
      // year and century boundaries
      year[7:0] = ($urandom_range(0, 1) != 0) ? 8'h99 : 8'h00;
      if ($urandom_range(0, 3) == 0) year[15:8] = 8'h99;
      mon = ($urandom_range(0, 1) != 0) ? 12 : 2;
    end else if (pick < 45) begin
      mon = 2;
    end
    day = (pick < 80) ? $urandom_range(27, 31) : $urandom_range(1, 31);
    return {year, to_bcd(mon), to_bcd(day)};
  endfunction

  // optional date load, time load, then a burst of ticks
  task automatic run_sequence;
    int ticks;
    logic [31:0] tval;
    if ($urandom_range(0, 99) < 60)
      send_item(MODE_LOAD_DATE, random_load_date(), 1'b0, '0);
    tval = random_load_time();
    send_item(MODE_LOAD_TIME, tval, 1'b0, '0);
    // longer bursts when starting at the alarm minute
    ticks = (tval[21:8] == alarm_at[21:8]) ? $urandom_range(1, 70) : $urandom_range(1, 15);
    repeat (ticks) send_item(MODE_TICK, $urandom(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [31:0] phase_alarm;
    logic        phase_enable;
    int          phase_end;
    int          i;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_TICK;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    cur_tod = TIME_RESET;
    cur_date = DATE_RESET;
    alarm_at = '0;
    alarm_on = 1'b0;

    // directed rows; typed results hold right after reset, at extremes and wraps
    dir_rows = '{
      '{MODE_TICK,      32'h0000_0000, 1'b1, '{22'h000001, 32'h2017_0408, 1'b0, 1'b0}},
      // alarm set to 00:00:02 below
      '{MODE_TICK,      32'hFFFF_FFFF, 1'b1, '{22'h000002, 32'h2017_0408, 1'b1, 1'b0}},
      // unused mode leaves everything alone
      '{MODE_UNUSED,    32'hFFFF_FFFF, 1'b1, '{22'h000002, 32'h2017_0408, 1'b0, 1'b0}},
      '{MODE_LOAD_TIME, 32'hFFFF_FFFF, 1'b1, '{22'h3FFFFF, 32'h2017_0408, 1'b0, 1'b0}},
      // all-ones time wraps through the non-bcd carries
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0},
      '{MODE_LOAD_DATE, 32'h9999_1231, 1'b1, '{22'h000000, 32'h9999_1231, 1'b0, 1'b0}},
      '{MODE_LOAD_TIME, 32'h0023_5959, 1'b1, '{22'h235959, 32'h9999_1231, 1'b0, 1'b0}},
      // year 9999 wraps to 0000
      '{MODE_TICK,      32'h0000_0000, 1'b1, '{22'h000000, 32'h0000_0101, 1'b0, 1'b1}},
      // leap february by the low year digits
      '{MODE_LOAD_DATE, 32'h2024_0228, 1'b0, '0},
      '{MODE_LOAD_TIME, 32'h0023_5959, 1'b0, '0},
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0},
      '{MODE_LOAD_TIME, 32'h0023_5959, 1'b0, '0},
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0},
      // century year that is not a leap year
      '{MODE_LOAD_DATE, 32'h2100_0228, 1'b0, '0},
      '{MODE_LOAD_TIME, 32'h0023_5959, 1'b0, '0},
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0},
      // day zero in month zero
      '{MODE_LOAD_DATE, 32'h0000_0000, 1'b1, '{22'h000000, 32'h0000_0000, 1'b0, 1'b0}},
      '{MODE_LOAD_TIME, 32'h0023_5959, 1'b0, '0},
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0},
      // month above 12 with every year digit out of range
      '{MODE_LOAD_DATE, 32'hFFFF_FFFF, 1'b1, '{22'h000000, 32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{MODE_LOAD_TIME, 32'h0023_5959, 1'b0, '0},
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0},
      // bits above the time field are dropped
      '{MODE_LOAD_TIME, 32'hFFC0_0001, 1'b1, '{22'h000001, 32'h0000_0101, 1'b0, 1'b0}},
      '{MODE_TICK,      32'h0000_0000, 1'b0, '0}
    };

    // synchronous reset, released at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(REG_ALARM_TIME, 32'h0000_0002);
    cfg_write(REG_ALARM_EN, 32'h0000_0001);
    for (i = 0; i < NUM_DIRECTED; i++)
      send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    // random phases, each with its own alarm setting
    for (i = 0; i < NUM_PHASES; i++) begin
      drain();
      case (i)
        0: begin phase_alarm = 32'h0000_0000; phase_enable = 1'b1; end
        1: begin phase_alarm = 32'hFFFF_FFFF; phase_enable = 1'b1; end
        3: begin phase_alarm = {10'h0, random_valid_time()}; phase_enable = 1'b0; end
        5: begin phase_alarm = 32'h0023_5959; phase_enable = 1'b1; end
        default: begin phase_alarm = {10'h0, random_valid_time()}; phase_enable = 1'b1; end
      endcase
      cfg_write(REG_ALARM_TIME, phase_alarm);
      cfg_write(REG_ALARM_EN, {31'h0, phase_enable});
      calm = (i == 2);        // one long stretch with no idling
      stall_req = (i == 4);   // one long hold-off on the result side
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 15)
          send_item(rtcc_mode_t'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
        else
          run_sequence();
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
